### rtl/wsf_pkg.sv
// Package for the windowed-sinc low-pass FIR: pipeline control type and kernel builder.
`default_nettype none

package wsf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 16;
    localparam int OUT_W    = 20;
    localparam int FRAC_W   = 13;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic signed [63:0] TWO_PI_Q28   = 64'sd1686629713;
    localparam logic signed [63:0] HAM_A_Q28    = 64'sd144955146;
    localparam logic signed [63:0] HAM_B_Q28    = 64'sd123480310;
    localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;

    // pipeline control handed from the top level to the datapath modules
    typedef struct packed {
        logic advance;
        logic accept;
    } ctl_t;

    // floor((v + 2^(n-1)) / 2^n)
    function automatic logic signed [63:0] rsh_round(logic signed [63:0] v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // shift-subtract long division, elaboration only
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // signed quotient truncated toward zero, positive divisor
    function automatic logic signed [63:0] sdiv_trunc(logic signed [63:0] a,
                                                      logic [63:0] d);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        neg = a[63];
        mag = neg ? 64'(-a) : 64'(a);
        q   = udiv64(mag, d);
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // num/den of a turn as a 32-bit phase, rounded to nearest
    function automatic logic [31:0] turn_phase(logic [31:0] num, logic [31:0] den);
        logic [63:0] p;
        p = udiv64(({32'b0, num} << 32) + {33'b0, den[31:1]}, {32'b0, den});
        return p[31:0];
    endfunction

    // sine of a 32-bit phase in Q28, quadrant fold plus Taylor series
    function automatic logic signed [63:0] sin_q28(logic [31:0] phase);
        logic              neg;
        logic [31:0]       pp;
        logic [63:0]       xu;
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        int                n;
        neg = 1'b0;
        pp  = phase;
        if (pp >= HALF_TURN)
        begin
            neg = 1'b1;
            pp  = pp - HALF_TURN;
        end
        if (pp > QUARTER_TURN)
        begin
            pp = HALF_TURN - pp;
        end
        xu   = ({32'b0, pp} * 64'd1686629713 + 64'h8000_0000) >> 32;
        x    = $signed(xu);
        x2   = rsh_round(x * x, 28);
        term = x;
        sum  = x;
        for (n = 1; n <= 12; n++)
        begin
            term = -sdiv_trunc(rsh_round(term * x2, 28), 64'((2 * n) * (2 * n + 1)));
            sum  = sum + term;
        end
        return neg ? -sum : sum;
    endfunction

    // Q3.13 tap i of a Hamming-windowed sinc kernel, not normalized
    function automatic logic signed [TAP_W-1:0] kernel_tap(int i, int taps, int cutoff);
        int                 k;
        int                 ak;
        logic [31:0]        num;
        logic signed [63:0] s;
        logic [31:0]        cp;
        logic signed [63:0] c;
        logic signed [63:0] win;
        logic signed [63:0] q28;
        logic signed [63:0] t;
        k = i - (taps >> 1);
        if (k == 0)
        begin
            q28 = (TWO_PI_Q28 * 64'(cutoff) + 64'sd500) / 64'sd1000;
        end
        else
        begin
            ak  = (k < 0) ? -k : k;
            num = 32'((cutoff * ak) % 1000);
            s   = sdiv_trunc(sin_q28(turn_phase(num, 32'd1000)), 64'(ak));
            cp  = turn_phase(32'(i), 32'(taps - 1)) + QUARTER_TURN;
            c   = sin_q28(cp);
            win = HAM_A_Q28 - rsh_round(HAM_B_Q28 * c, 28);
            q28 = rsh_round(s * win, 28);
        end
        t = rsh_round(q28, 15);
        if (t > 64'sd32767)
        begin
            return 16'sh7fff;
        end
        if (t < -64'sd32768)
        begin
            return 16'sh8000;
        end
        return t[TAP_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/windowed_sinc_lowpass_fir.sv
// Top level of the streaming Hamming-windowed sinc low-pass FIR filter.
//
// Input channel: sample_valid / sample_ready carry one signed 16-bit sample
// per word. Output channel: result_valid / result_ready carry filtered
// (signed 20 bits, Q13 sum rounded and saturated) and clipped.
// The taps are fixed at build time from TAPS and CUTOFF_THOUSANDTHS.
// The first TAPS-1 samples after reset only fill the delay line and give
// no result; every sample after that gives exactly one result.
// Throughput: one sample per cycle while the output is not stalled. From
// acceptance to result_valid a word passes the delay-line register, the
// product register, the registered adder tree and the output register.
// Reset clears the fill count and the pipeline valid bits; no result is pending.
// When the receiver stalls, the result is held in the output register and
// the pipeline keeps moving until a valid word reaches its last stage;
// only then does sample_ready drop.
`default_nettype none

module windowed_sinc_lowpass_fir
    import wsf_pkg::*;
#(
    parameter int TAPS               = 29,
    parameter int CUTOFF_THOUSANDTHS = 200
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       sample_valid,
    output logic                            sample_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output logic signed [OUT_W-1:0]         filtered,
    output logic                            clipped
);

    localparam int LEVELS = $clog2(TAPS);
    localparam int ACC_W  = 2 * SAMPLE_W + LEVELS;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX    = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] ACC_MIN    = ACC_W'(OUT_MIN);

    ctl_t                       ctl;
    logic signed [SAMPLE_W-1:0] hist [TAPS];
    logic                       hist_valid;
    logic signed [ACC_W-1:0]    sum;
    logic                       sum_valid;
    logic signed [ACC_W-1:0]    scaled;
    logic signed [OUT_W-1:0]    filt_next;
    logic                       clip_next;
    logic signed [OUT_W-1:0]    filt_reg;
    logic                       clip_reg;
    logic                       res_vld_reg;
    logic                       res_vld_next;

    // advance unless a finished word would overwrite one still waiting
    assign ctl.advance  = !res_vld_reg || result_ready || !sum_valid;
    assign ctl.accept   = sample_valid && ctl.advance;
    assign sample_ready = ctl.advance;

    wsf_tap_line #(
        .TAPS (TAPS)
    ) u_tap_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sample     (sample),
        .hist       (hist),
        .hist_valid (hist_valid)
    );

    wsf_mac_tree #(
        .TAPS               (TAPS),
        .CUTOFF_THOUSANDTHS (CUTOFF_THOUSANDTHS),
        .LEVELS             (LEVELS),
        .ACC_W              (ACC_W)
    ) u_mac_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .hist       (hist),
        .hist_valid (hist_valid),
        .sum        (sum),
        .sum_valid  (sum_valid)
    );

    always_comb
    begin
        scaled = (sum + ROUND_HALF) >>> FRAC_W;
        priority if (scaled > ACC_MAX)
        begin
            filt_next = OUT_MAX;
            clip_next = 1'b1;
        end
        else if (scaled < ACC_MIN)
        begin
            filt_next = OUT_MIN;
            clip_next = 1'b1;
        end
        else
        begin
            filt_next = scaled[OUT_W-1:0];
            clip_next = 1'b0;
        end
    end

    always_comb
    begin
        res_vld_next = res_vld_reg;
        if (ctl.advance && sum_valid)
        begin
            res_vld_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && sum_valid)
        begin
            filt_reg <= filt_next;
            clip_reg <= clip_next;
        end
    end

    assign result_valid = res_vld_reg;
    assign filtered     = filt_reg;
    assign clipped      = clip_reg;

    a_clip_rail : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && clipped |-> filtered == OUT_MAX || filtered == OUT_MIN)
        else $error("clipped word not at a rail");

    a_stall_block : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && sum_valid |-> !sample_ready)
        else $error("pipeline advanced over a waiting result");

endmodule

`default_nettype wire

### rtl/wsf_tap_line.sv
// Sample delay line with fill tracking for the windowed-sinc FIR.
`default_nettype none

module wsf_tap_line
    import wsf_pkg::*;
#(
    parameter int TAPS = 29
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ctl_t                       ctl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0]      hist [TAPS],
    output logic                            hist_valid
);

    localparam int FILL_W = $clog2(TAPS);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAPS - 1);

    logic signed [SAMPLE_W-1:0] hist_reg [TAPS];
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_next;
    logic                       vld_reg;
    logic                       vld_next;
    logic                       full;

    assign full = (fill_reg == FILL_FULL);

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.accept && !full)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        vld_next = vld_reg;
        if (ctl.advance)
        begin
            // a word yields a result only once the window is full
            vld_next = ctl.accept && full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            vld_reg  <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i < TAPS; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    assign hist       = hist_reg;
    assign hist_valid = vld_reg;

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count past window length");

    a_fill_step : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept && !full |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("fill count missed an accepted word");

endmodule

`default_nettype wire

### rtl/wsf_mac_tree.sv
// Constant-tap products and registered adder tree for the windowed-sinc FIR.
`default_nettype none

module wsf_mac_tree
    import wsf_pkg::*;
#(
    parameter int TAPS               = 29,
    parameter int CUTOFF_THOUSANDTHS = 200,
    parameter int LEVELS             = 5,
    parameter int ACC_W              = 37
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ctl_t                       ctl,
    input  wire logic signed [SAMPLE_W-1:0] hist [TAPS],
    input  wire logic                       hist_valid,
    output logic signed [ACC_W-1:0]         sum,
    output logic                            sum_valid
);

    localparam int LEAVES = 1 << LEVELS;

    // heap layout: node 1 is the root, leaves at LEAVES..2*LEAVES-1
    logic signed [ACC_W-1:0] node_reg [1:2*LEAVES-1];
    logic [LEVELS:0]         vld_reg;

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            localparam logic signed [TAP_W-1:0] WEIGHT =
                (g < TAPS) ? kernel_tap(g, TAPS, CUTOFF_THOUSANDTHS) : '0;
            localparam int SRC = (g < TAPS) ? g : 0;

            always_ff @(posedge clk)
            begin
                if (ctl.advance)
                begin
                    node_reg[LEAVES+g] <= ACC_W'(hist[SRC] * WEIGHT);
                end
            end
        end

        for (g = 1; g < LEAVES; g++)
        begin : g_node
            always_ff @(posedge clk)
            begin
                if (ctl.advance)
                begin
                    node_reg[g] <= node_reg[2*g] + node_reg[2*g+1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.advance)
        begin
            vld_reg <= {vld_reg[LEVELS-1:0], hist_valid};
        end
    end

    assign sum       = node_reg[1];
    assign sum_valid = vld_reg[LEVELS];

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.advance |=> vld_reg == $past(vld_reg))
        else $error("tree valid moved during a stall");

endmodule

`default_nettype wire
